FILE: hdl/gmps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_pkg: shared types and constants
// Fixed-point widths, state encodings and the exp2 root table.
// ----------------------------------------------------------------------------
package gmps_pkg;

  localparam int SAMPLE_W   = 16;   // dwi_sample, two's complement
  localparam int CFG_W      = 9;    // sample_count register
  localparam int CFG_MAX    = 511;  // largest value the register can hold
  localparam int SUM_W      = 28;   // log_sum, Q12.16
  localparam int FRAC_W     = 16;   // fraction bits of a log / mean
  localparam int LOG_INT_W  = 4;    // integer part of one log2, 0..14
  localparam int LOG_W      = LOG_INT_W + FRAC_W;
  localparam int Y_W        = 31;   // Q1.30 working value, always below 2.0
  localparam int Y_FRAC     = 30;
  localparam int STEP_W     = 4;    // counts FRAC_W steps
  localparam int DIV_CNT_W  = 5;    // counts SUM_W quotient bits
  localparam int OUT_W      = 23;   // geometric_mean, Q15.8
  localparam int SHIFT_DROP = 22;   // Q1.30 -> Q15.8
  localparam int EXP_INT_W  = SUM_W - FRAC_W;
  localparam int EXP_SAT    = 15;   // integer exponent at which output saturates
  localparam int EXP_SH_W   = 4;    // shift amount below EXP_SAT
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
  localparam logic [Y_W-1:0]   Y_ONE   = Y_W'(64'h4000_0000);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_LOG  = 3'b010,
    F_EMIT = 3'b100
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_EXP  = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_t;

  // Integer square root, bit by bit; used only at elaboration.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q1.30 roots 2^(2^-k), k = 1..16, each one the truncated root of the last.
  function automatic logic [FRAC_W*Y_W-1:0] exp_roots();
    logic [63:0] c;
    logic [FRAC_W*Y_W-1:0] tbl;
    c   = 64'h8000_0000;
    tbl = '0;
    for (int k = 0; k < FRAC_W; k++) begin
      c = isqrt64(c << Y_FRAC);
      tbl[k*Y_W +: Y_W] = c[Y_W-1:0];
    end
    return tbl;
  endfunction

  localparam logic [FRAC_W*Y_W-1:0] ROOTS = exp_roots();

endpackage

FILE: hdl/geometric_mean_positive_samples_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geometric_mean_positive_samples_unit: per-voxel geometric mean
// Sums fixed-point log2 of positive samples over a voxel and emits
// exp2(sum / count) in unsigned Q15.8.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload               Dir
//  -------   ------------------   -------------------   ---
//  sample    push / full          dwi_sample[15:0] s    in
//  result    pop / empty          geometric_mean[22:0]  out
//  config    cfg_valid/cfg_ready  cfg_data[8:0]         in
//
//  Front: a positive sample is accepted, then takes one squaring step per
//  log2 fraction bit; a zero or negative sample is done on acceptance. The
//  last sample of a voxel adds a state that hands the sum to the queue.
//  Back: per voxel, a restoring divide with one step per quotient bit, 16
//  exp2 steps, then a load of the output register. The two-entry queue lets
//  the front keep taking samples of the next voxels meanwhile.
//  Reset clears the sum, the sample index and the queue; sample_count goes to
//  1. No clearing pass. A config write restarts the current voxel.
//  The output register holds its request while pop is low.
//
module geometric_mean_positive_samples_unit import gmps_pkg::*; #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                clk,
  input  logic                rst,
  // samples
  input  logic                push,
  output logic                full,
  input  logic [SAMPLE_W-1:0] dwi_sample,
  // results
  output logic                empty,
  input  logic                pop,
  output logic [OUT_W-1:0]    geometric_mean,
  // sample_count register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data
);

  // effective count never exceeds what the register can hold
  localparam int CAP   = (MAX_SAMPLES < CFG_MAX) ? MAX_SAMPLES : CFG_MAX;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int QW    = SUM_W + CNT_W;

  logic             cfg_we;
  logic             q_push;
  logic [SUM_W-1:0] f_sum;
  logic [CNT_W-1:0] f_count;
  logic             q_full;
  logic             q_empty;
  logic             q_rd;
  logic [QW-1:0]    q_rdata;

  // the register is always writable; writes are expected while idle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  gmps_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .push       (push),
    .dwi_sample (dwi_sample),
    .full       (full),
    .q_push     (q_push),
    .q_sum      (f_sum),
    .q_count    (f_count),
    .q_full     (q_full)
  );

  // one request per voxel: {log sum, count}
  gmps_queue #(
    .W (QW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wdata   ({f_sum, f_count}),
    .q_full  (q_full),
    .rd      (q_rd),
    .rdata   (q_rdata),
    .q_empty (q_empty)
  );

  gmps_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_sum          (q_rdata[QW-1:CNT_W]),
    .q_count        (q_rdata[CNT_W-1:0]),
    .q_rd           (q_rd),
    .empty          (empty),
    .pop            (pop),
    .geometric_mean (geometric_mean)
  );

endmodule

FILE: hdl/gmps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_front: sample intake and log accumulation
// Takes samples, runs a bit-serial log2 on positive ones, sums per voxel and
// hands the finished sum and count to the queue.
// ----------------------------------------------------------------------------
module gmps_front import gmps_pkg::*; #(
  parameter int MAX_SAMPLES = 256,
  parameter int CNT_W       = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                push,
  input  logic [SAMPLE_W-1:0] dwi_sample,
  output logic                full,
  output logic                q_push,
  output logic [SUM_W-1:0]    q_sum,
  output logic [CNT_W-1:0]    q_count,
  input  logic                q_full
);

  localparam int CAP = (MAX_SAMPLES < CFG_MAX) ? MAX_SAMPLES : CFG_MAX;

  front_state_t          state;
  logic [CFG_W-1:0]      sample_count;
  logic [SUM_W-1:0]      log_sum;
  logic [CNT_W-1:0]      idx;
  logic [LOG_INT_W-1:0]  n;
  logic [Y_W-1:0]        y;
  logic [FRAC_W-1:0]     frac;
  logic [STEP_W-1:0]     step;

  logic [CNT_W-1:0]      count_eff;
  logic [CNT_W:0]        idx_inc;
  logic                  last;
  logic                  accept;
  logic                  positive;
  logic [LOG_INT_W-1:0]  lead_n;
  logic [Y_W-1:0]        y_init;
  logic [2*Y_W-1:0]      prod;
  logic [Y_W:0]          sq;
  logic                  sq_bit;
  logic [Y_W-1:0]        y_step;
  logic [LOG_W-1:0]      log_val;
  logic [SUM_W:0]        sum_ext;
  logic [SUM_W-1:0]      sum_sat;

  always_comb begin
    if (sample_count == '0) begin
      count_eff = CNT_W'(1);
    end else if (sample_count > CFG_W'(CAP)) begin
      count_eff = CNT_W'(CAP);
    end else begin
      count_eff = sample_count[CNT_W-1:0];
    end
  end

  assign idx_inc  = {1'b0, idx} + (CNT_W+1)'(1);
  assign last     = idx_inc >= {1'b0, count_eff};
  assign full     = (state != F_IDLE);
  assign accept   = push && !full;
  assign positive = !dwi_sample[SAMPLE_W-1] && (dwi_sample != '0);

  // top set bit of the sample
  always_comb begin
    lead_n = '0;
    for (int b = 1; b < SAMPLE_W - 1; b++) begin
      if (dwi_sample[b]) lead_n = LOG_INT_W'(b);
    end
  end

  assign y_init = Y_W'(dwi_sample[SAMPLE_W-2:0]) << (5'(Y_FRAC) - {1'b0, lead_n});

  // one squaring step of the fraction
  assign prod    = y * y;
  assign sq      = prod[2*Y_W-1:Y_FRAC];
  assign sq_bit  = sq[Y_W];
  assign y_step  = sq_bit ? sq[Y_W:1] : sq[Y_W-1:0];

  assign log_val = {n, frac[FRAC_W-2:0], sq_bit};
  assign sum_ext = {1'b0, log_sum} + (SUM_W+1)'(log_val);
  assign sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

  assign q_push  = (state == F_EMIT) && !q_full;
  assign q_sum   = log_sum;
  assign q_count = count_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      sample_count <= CFG_W'(1);
      log_sum      <= '0;
      idx          <= '0;
    end else if (cfg_we) begin
      state        <= F_IDLE;
      sample_count <= cfg_data;
      log_sum      <= '0;
      idx          <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (positive) begin
              state <= F_LOG;
            end else if (last) begin
              state <= F_EMIT;
            end else begin
              idx <= idx_inc[CNT_W-1:0];
            end
          end
        end
        F_LOG: begin
          if (step == STEP_W'(FRAC_W - 1)) begin
            log_sum <= sum_sat;
            if (last) begin
              state <= F_EMIT;
            end else begin
              idx   <= idx_inc[CNT_W-1:0];
              state <= F_IDLE;
            end
          end
        end
        F_EMIT: begin
          if (!q_full) begin
            log_sum <= '0;
            idx     <= '0;
            state   <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // log2 datapath
  always_ff @(posedge clk) begin
    if (accept && positive) begin
      n    <= lead_n;
      y    <= y_init;
      frac <= '0;
      step <= '0;
    end else if (state == F_LOG) begin
      y    <= y_step;
      frac <= {frac[FRAC_W-2:0], sq_bit};
      step <= step + STEP_W'(1);
    end
  end

endmodule

FILE: hdl/gmps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_queue: two-entry request queue
// Decouples the accumulation front from the divide / exp2 back end.
// ----------------------------------------------------------------------------
module gmps_queue import gmps_pkg::*; #(
  parameter int W = 37
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         q_full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         q_empty
);

  logic [W-1:0]      mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   fill;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) wptr <= wptr + QPTR_W'(1);
      if (do_rd) rptr <= rptr + QPTR_W'(1);
      if (do_wr && !do_rd) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: hdl/gmps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_back: mean and exp2 per voxel
// Restoring divide of the log sum by the count, then a root-product exp2,
// result held in an output register.
// ----------------------------------------------------------------------------
module gmps_back import gmps_pkg::*; #(
  parameter int CNT_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  logic [SUM_W-1:0] q_sum,
  input  logic [CNT_W-1:0] q_count,
  output logic             q_rd,
  output logic             empty,
  input  logic             pop,
  output logic [OUT_W-1:0] geometric_mean
);

  back_state_t          state;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W-1:0]     divisor;
  logic [CNT_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [STEP_W-1:0]    ecnt;
  logic [Y_W-1:0]       acc;
  logic                 out_valid;

  logic [CNT_W:0]       shifted;
  logic                 ge;
  logic [CNT_W:0]       diff;
  logic [Y_W-1:0]       root;
  logic [2*Y_W-1:0]     prod;
  logic [Y_W+EXP_SAT-2:0] scaled;
  logic [OUT_W-1:0]     result;
  logic                 load_out;

  // restoring divide step
  assign shifted = {rem, quo[SUM_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  // exp2 step: multiply by the root for fraction bit 15-ecnt
  assign root = ROOTS[ecnt*Y_W +: Y_W];
  assign prod = acc * root;

  assign scaled = (Y_W+EXP_SAT-1)'(acc) << quo[FRAC_W +: EXP_SH_W];
  assign result = (quo[SUM_W-1:FRAC_W] >= EXP_INT_W'(EXP_SAT)) ? OUT_MAX
                : scaled[Y_W+EXP_SAT-2:SHIFT_DROP];

  assign q_rd     = (state == B_IDLE) && !q_empty;
  assign load_out = (state == B_OUT) && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE:  if (!q_empty) state <= B_DIV;
        B_DIV:   if (dcnt == DIV_CNT_W'(SUM_W - 1)) state <= B_EXP;
        B_EXP:   if (ecnt == STEP_W'(FRAC_W - 1)) state <= B_OUT;
        B_OUT:   if (load_out) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        quo     <= q_sum;
        divisor <= q_count;
        rem     <= '0;
        dcnt    <= '0;
      end
      B_DIV: begin
        quo  <= {quo[SUM_W-2:0], ge};
        rem  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        dcnt <= dcnt + DIV_CNT_W'(1);
        acc  <= Y_ONE;
        ecnt <= '0;
      end
      B_EXP: begin
        // running product stays below 2.0, so the top bit is always clear
        if (quo[FRAC_W - 1 - ecnt]) acc <= prod[Y_FRAC+Y_W-1:Y_FRAC];
        ecnt <= ecnt + STEP_W'(1);
      end
      B_OUT: begin
        if (load_out) geometric_mean <= result;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/gmps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_checker: port-level checks
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module gmps_checker import gmps_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [OUT_W-1:0]    geometric_mean,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  // a waiting result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(geometric_mean))
    else $error("result changed or vanished while not popped");

  // nothing is left in the output after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present right after reset");

  // the front is ready to take a sample right after reset
  a_rst_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input full right after reset");

  // a register write restarts the voxel, so the input opens again
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !full)
    else $error("input full after a config write");

endmodule

bind geometric_mean_positive_samples_unit gmps_checker u_gmps_checker (.*);

FILE: verif/geometric_mean_positive_samples_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geometric_mean_positive_samples_unit_test: self-checking bench
// Feeds voxels of signed samples through the push/full queue port. Each
// accepted request updates a bit-true model of the log2 sum, divide and exp2.
// The model queues the expected means, and every popped result is checked
// against the oldest one. Phases change sample_count between 0, 511, 256 and
// small counts, and run with and without sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module geometric_mean_positive_samples_unit_test;
  import gmps_pkg::*;

  localparam int MAX_VOXEL     = 256;   // DUT MAX_SAMPLES default
  localparam int SETTLE_CYCLES = 80;    // front log stage, back divide and exp2, plus margin
  localparam int QUIET_LIMIT   = 4000;  // cycles with no request moving at all
  localparam int REPORT_MAX    = 10;

  // Traffic shaping per phase
  typedef enum logic [1:0] {
    TRAFFIC_FREE,
    TRAFFIC_SEND_GAPS,
    TRAFFIC_RECV_STALLS,
    TRAFFIC_BOTH_LIGHT
  } traffic_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 push       = 1'b0;
  logic                 full;
  logic [SAMPLE_W-1:0]  dwi_sample = '0;
  logic                 empty;
  logic                 pop        = 1'b0;
  logic [OUT_W-1:0]     geometric_mean;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data   = '0;

  // Stimulus backlog and expected means
  logic [SAMPLE_W-1:0]  sample_backlog [$];
  logic [OUT_W-1:0]     gm_expected [$];

  // Model state: mirrors the block's sum, index and clamped count
  logic [SUM_W-1:0]     acc_log_sum = '0;
  int                   acc_samples = 0;
  int                   voxel_len   = 1;   // reset value of sample_count
  logic [63:0]          root_q30 [1:FRAC_W];

  int                   fill_pos         = 0;   // position of next queued sample in voxel
  int unsigned          sender_idle_pct  = 0;
  int unsigned          recv_stall_pct   = 0;
  int unsigned          quiet_cycles     = 0;
  int                   errors           = 0;
  int                   samples_accepted = 0;
  int                   means_checked    = 0;
  int                   count_writes     = 0;
  int                   phases           = 0;
  logic [SAMPLE_W-1:0]  corner_samples [18];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  geometric_mean_positive_samples_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .dwi_sample     (dwi_sample),
    .empty          (empty),
    .pop            (pop),
    .geometric_mean (geometric_mean),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Fixed-point model
  // --------------------------------------------------------------------------

  // floor(sqrt(v)), one result bit at a time from the top
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Q4.16 log2 of a positive 15-bit magnitude; fraction by repeated squaring
  function automatic logic [LOG_W-1:0] fixed_log2(input logic [SAMPLE_W-2:0] x);
    int                n;
    logic [63:0]       y;
    logic [FRAC_W-1:0] frac;
    n    = 0;
    frac = '0;
    for (int b = 0; b < SAMPLE_W - 1; b++)
      if (x[b]) n = b;
    y = 64'(x) << (Y_FRAC - n);
    for (int k = 0; k < FRAC_W; k++) begin
      y    = (y * y) >> Y_FRAC;
      frac = {frac[FRAC_W-2:0], 1'b0};
      if (y >= (64'd1 << (Y_FRAC + 1))) begin
        frac[0] = 1'b1;
        y       = y >> 1;
      end
    end
    return {LOG_INT_W'(n), frac};
  endfunction

  // Q15.8 of 2^q, q in Q12.16; product of per-bit roots, then integer shift
  function automatic logic [OUT_W-1:0] fixed_exp2(input logic [SUM_W-1:0] q);
    logic [63:0] a;
    logic [63:0] r;
    int          ipart;
    ipart = int'(q >> FRAC_W);
    if (ipart >= EXP_SAT) return OUT_MAX;
    a = 64'd1 << Y_FRAC;
    for (int k = 1; k <= FRAC_W; k++)
      if (q[FRAC_W-k]) a = (a * root_q30[k]) >> Y_FRAC;
    r = (a << ipart) >> SHIFT_DROP;
    if (r > 64'(OUT_MAX)) return OUT_MAX;
    return r[OUT_W-1:0];
  endfunction

  function automatic int clamp_count(input int value);
    if (value < 1) return 1;
    if (value > MAX_VOXEL) return MAX_VOXEL;
    return value;
  endfunction

  // One accepted sample: add its log when strictly positive, close the voxel
  // when the count is reached.
  function automatic void take_sample(input logic signed [SAMPLE_W-1:0] s);
    logic [SUM_W:0] sum;
    if (s > 0) begin
      sum         = {1'b0, acc_log_sum} + fixed_log2(s[SAMPLE_W-2:0]);
      acc_log_sum = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
    end
    acc_samples++;
    if (acc_samples >= voxel_len) begin
      gm_expected.push_back(fixed_exp2(SUM_W'(acc_log_sum / voxel_len)));
      acc_log_sum = '0;
      acc_samples = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Positive magnitudes spread over every octave; zeros and negatives mixed in.
  function automatic logic [SAMPLE_W-1:0] draw_sample(input bit may_be_positive);
    int unsigned pick;
    int unsigned mag;
    pick = may_be_positive ? $urandom_range(99) : $urandom_range(99, 60);
    if (pick < 60) begin
      mag = $urandom_range(32767, 1) >> $urandom_range(14);
      if (mag == 0) mag = 1;
      return SAMPLE_W'(mag);
    end
    if (pick < 75) return '0;
    return SAMPLE_W'(-int'($urandom_range(32768, 1)));
  endfunction

  // Whole voxels of random content; about one voxel in ten has no positive
  // sample, which must come back as exactly 1.0.
  task automatic queue_samples(input int n);
    bit dry;
    dry = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (fill_pos % voxel_len == 0) dry = ($urandom_range(9) == 0);
      sample_backlog.push_back(draw_sample(!dry));
      fill_pos++;
    end
  endtask

  task automatic set_traffic(input traffic_t mode);
    case (mode)
      TRAFFIC_FREE: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
      TRAFFIC_SEND_GAPS: begin
        sender_idle_pct = 79;
        recv_stall_pct  = 0;
      end
      TRAFFIC_RECV_STALLS: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 79;
      end
      default: begin
        sender_idle_pct = 10;
        recv_stall_pct  = 10;
      end
    endcase
  endtask

  // Nothing left to send, nothing in flight that produces a mean
  task automatic wait_drained();
    while (sample_backlog.size() != 0 || push || gm_expected.size() != 0)
      @(negedge clk);
  endtask

  // Register write; only called when the block is idle. The write also
  // restarts the voxel, so the model's sum and index clear with it.
  task automatic write_sample_count(input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    voxel_len   = clamp_count(value);
    acc_log_sum = '0;
    acc_samples = 0;
    fill_pos    = 0;
    count_writes++;
  endtask

  // One setting of sample_count. A partial voxel at the end is left for the
  // next write to discard. With hold_midway the sender stops halfway until
  // every mean is back, then goes on with the same voxel stream.
  task automatic run_phase(input int value, input int n, input traffic_t mode,
                           input bit hold_midway);
    write_sample_count(value);
    @(negedge clk);
    set_traffic(mode);
    if (hold_midway) begin
      queue_samples(n / 2);
      wait_drained();
      queue_samples(n - n / 2);
    end else begin
      queue_samples(n);
    end
    wait_drained();
    // a trailing non-final sample may still be in the log stage
    repeat (SETTLE_CYCLES) @(negedge clk);
    phases++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: one request per accepted sample; push stays high while full
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        take_sample(dwi_sample);
        samples_accepted++;
      end
      if (!push || !full) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          push       <= 1'b1;
          dwi_sample <= sample_backlog.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each popped mean with the oldest expected one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (gm_expected.size() == 0) begin
          if (errors < REPORT_MAX)
            $display("ERROR: mean %0d popped with none expected", geometric_mean);
          errors++;
        end else begin
          logic [OUT_W-1:0] want;
          want = gm_expected.pop_front();
          if (geometric_mean !== want) begin
            if (errors < REPORT_MAX)
              $display("ERROR: geometric_mean expected %0d (0x%06h) got %0d (0x%06h)",
                       want, want, geometric_mean, geometric_mean);
            errors++;
          end
          means_checked++;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any sample, result or register request resets the count
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
      $display("geometric_mean_positive_samples_unit_test NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0] c;
    // Q1.30 roots 2^(2^-k), each the truncated root of the previous one
    c = 64'd1 << (Y_FRAC + 1);
    for (int k = 1; k <= FRAC_W; k++) begin
      c           = int_sqrt(c << Y_FRAC);
      root_q30[k] = c;
    end

    // Extremes at the reset count of one: each sample is its own voxel, so
    // the mean is about the sample itself; every non-positive one gives 1.0.
    corner_samples = '{16'h0001, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0002,
                       16'h0003, 16'h4000, 16'h5555, 16'h2AAA, 16'h00FF, 16'h0100,
                       16'h7FFE, 16'h1000, 16'h3039, 16'h8001, 16'h0005, 16'h6ED9};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    set_traffic(TRAFFIC_FREE);
    foreach (corner_samples[i]) sample_backlog.push_back(corner_samples[i]);
    fill_pos = 18;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    phases++;

    // A count of zero acts as one
    run_phase(0, 24, TRAFFIC_SEND_GAPS, 1'b0);
    // Pairs, with a pause to full drain midway; ends on a half voxel
    run_phase(2, 41, TRAFFIC_RECV_STALLS, 1'b1);
    // All ones clamps to the maximum voxel size
    run_phase(511, 256, TRAFFIC_BOTH_LIGHT, 1'b0);
    // Ends three samples into a voxel; the next write drops them
    run_phase(7, 31, TRAFFIC_BOTH_LIGHT, 1'b0);
    run_phase(int'($urandom_range(8, 1)), 30, TRAFFIC_SEND_GAPS, 1'b0);
    run_phase(int'($urandom_range(8, 1)), 30, TRAFFIC_RECV_STALLS, 1'b0);
    run_phase(int'($urandom_range(8, 1)), 30, TRAFFIC_BOTH_LIGHT, 1'b0);
    // Largest legal count written as is
    run_phase(MAX_VOXEL, 256, TRAFFIC_FREE, 1'b0);

    if (gm_expected.size() != 0) begin
      $display("ERROR: %0d expected means never arrived", gm_expected.size());
      errors++;
    end

    $display("Run: %0d samples in %0d phases, %0d sample_count writes (0, 511, 256, small)",
             samples_accepted, phases, count_writes);
    $display("Run: %0d voxel means compared, %0d failures", means_checked, errors);
    if (errors == 0) begin
      $display("geometric_mean_positive_samples_unit_test OK");
    end else begin
      $display("geometric_mean_positive_samples_unit_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/gmps_pkg.sv
hdl/gmps_front.sv
hdl/gmps_queue.sv
hdl/gmps_back.sv
hdl/geometric_mean_positive_samples_unit.sv
hdl/gmps_checker.sv
verif/geometric_mean_positive_samples_unit_test.sv
